FILE: rtl/pifd_pkg.sv
`default_nettype none
package pifd_pkg;

	localparam int IMAGE_WIDTH    = 320;
	localparam int IMAGE_HEIGHT   = 200;
	localparam int HEAD_BYTES     = 2;
	localparam int DATA_START     = 34;
	localparam int GROUPS_PER_ROW = IMAGE_WIDTH / 16;
	localparam int IMAGE_END      = DATA_START + 8 * GROUPS_PER_ROW * IMAGE_HEIGHT;
	localparam int POS_W          = $clog2(IMAGE_END + 1);
	localparam int COL_W          = (GROUPS_PER_ROW > 1) ? $clog2(GROUPS_PER_ROW) : 1;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] file_byte;
		logic       new_file;
	} byte_beat_t;

	typedef struct packed {
		logic       item_kind;
		logic [3:0] color_index;
		logic [8:0] pixel_x;
		logic [7:0] pixel_y;
		logic [3:0] red_level;
		logic [3:0] green_level;
		logic [3:0] blue_level;
		logic       extended_palette;
		logic       header_error;
		logic       final_item;
	} result_beat_t;

	typedef enum logic [1:0] {
		CMD_PAL_HI,
		CMD_PAL_LO,
		CMD_GROUP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t       kind;
		logic [7:0][7:0] grp;
		logic [3:0]      pal_idx;
		logic [8:0]      x_base;
		logic [7:0]      row;
		logic            fresh;
		logic            last;
		logic            hdr;
	} cmd_t;

	typedef enum logic {
		BK_RUN,
		BK_PAL
	} bk_state_t;

	localparam logic KIND_PIXEL   = 1'b0;
	localparam logic KIND_PALETTE = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/pifd_front.sv
`default_nettype none
module pifd_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 byte_valid,
	output logic                byte_stall,
	input  pifd_pkg::byte_beat_t byte_data,
	input  wire                 q_full,
	output logic                q_push,
	output pifd_pkg::cmd_t      q_cmd
);

	logic [pifd_pkg::POS_W-1:0] pos_q, pos_eff;
	logic [pifd_pkg::COL_W-1:0] col_q, col_eff;
	logic [7:0]                 row_q, row_eff;
	logic                       hdr_q, hdr_eff;
	logic                       fresh_q, fresh_eff;
	logic [6:0][7:0]            gb_q;
	logic                       accept;
	logic                       in_image;
	logic                       in_head;
	logic                       in_pal;
	logic [4:0]                 off;
	logic [2:0]                 g;

	assign byte_stall = q_full;
	assign accept     = byte_valid && !byte_stall;

	assign pos_eff   = byte_data.new_file ? '0 : pos_q;
	assign col_eff   = byte_data.new_file ? '0 : col_q;
	assign row_eff   = byte_data.new_file ? '0 : row_q;
	assign hdr_eff   = byte_data.new_file ? 1'b0 : hdr_q;
	assign fresh_eff = byte_data.new_file | fresh_q;

	assign in_image = pos_eff < pifd_pkg::POS_W'(pifd_pkg::IMAGE_END);
	assign in_head  = pos_eff < pifd_pkg::POS_W'(pifd_pkg::HEAD_BYTES);
	assign in_pal   = !in_head && (pos_eff < pifd_pkg::POS_W'(pifd_pkg::DATA_START));
	assign off      = pos_eff[4:0] - 5'(pifd_pkg::HEAD_BYTES);
	assign g        = pos_eff[2:0] - 3'(pifd_pkg::DATA_START);

	always_comb begin
		q_push        = 1'b0;
		q_cmd.kind    = off[0] ? pifd_pkg::CMD_PAL_LO : pifd_pkg::CMD_PAL_HI;
		q_cmd.grp     = {gb_q, byte_data.file_byte};
		q_cmd.pal_idx = off[4:1];
		q_cmd.x_base  = 9'({col_eff, 4'b0000});
		q_cmd.row     = row_eff;
		q_cmd.fresh   = fresh_eff;
		q_cmd.last    = (pos_eff + 1'b1) == pifd_pkg::POS_W'(pifd_pkg::IMAGE_END);
		q_cmd.hdr     = hdr_eff;
		if (accept && in_image && !in_head) begin
			if (in_pal) begin
				q_push = 1'b1;
			end else if (g == 3'd7) begin
				q_push     = 1'b1;
				q_cmd.kind = pifd_pkg::CMD_GROUP;
				q_cmd.grp  = {byte_data.file_byte, gb_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			hdr_q   <= 1'b0;
			fresh_q <= 1'b1;
		end else if (accept) begin
			pos_q   <= pos_eff;
			col_q   <= col_eff;
			row_q   <= row_eff;
			hdr_q   <= hdr_eff;
			fresh_q <= fresh_eff;
			if (in_image) begin
				pos_q <= pos_eff + 1'b1;
				if (in_head) begin
					hdr_q <= hdr_eff | (byte_data.file_byte != 8'd0);
				end else if (!in_pal && g == 3'd7) begin
					fresh_q <= 1'b0;
					if (col_eff == pifd_pkg::COL_W'(pifd_pkg::GROUPS_PER_ROW - 1)) begin
						col_q <= '0;
						row_q <= row_eff + 8'd1;
					end else begin
						col_q <= col_eff + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_image && !in_head && !in_pal && g != 3'd7) begin
			gb_q[g] <= byte_data.file_byte;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/pifd_fifo.sv
`default_nettype none
module pifd_fifo (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  pifd_pkg::cmd_t  push_cmd,
	input  wire             pop,
	output logic            full,
	output logic            head_valid,
	output pifd_pkg::cmd_t  head_cmd
);

	pifd_pkg::cmd_t              mem_q [pifd_pkg::QUEUE_DEPTH];
	logic [pifd_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [pifd_pkg::QCNT_W-1:0] cnt_q;
	logic                        do_pop;

	assign full       = cnt_q == pifd_pkg::QCNT_W'(pifd_pkg::QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_cmd   = mem_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/pifd_back.sv
`default_nettype none
module pifd_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    head_valid,
	input  pifd_pkg::cmd_t         head_cmd,
	output logic                   pop,
	output logic                   result_valid,
	input  wire                    result_stall,
	output pifd_pkg::result_beat_t result_data
);

	pifd_pkg::bk_state_t    state_q, state_d;
	logic [3:0]             cnt_q;
	logic [15:0]            seen_q;
	logic                   hdr_q;
	logic [15:0]            pal_q [16];
	pifd_pkg::result_beat_t out_q, res;
	logic                   out_valid_q;
	logic                   can_emit;
	logic                   emit;
	logic                   emit_pix;
	logic                   pal_we;
	logic                   is_group;
	logic [3:0]             color;
	logic [15:0]            xbits;
	logic                   ext;
	logic [7:0]             hi, lo;
	logic                   used;

	assign can_emit     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result_data  = out_q;
	assign is_group     = head_valid && head_cmd.kind == pifd_pkg::CMD_GROUP;

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			color[b] = head_cmd.grp[2 * b + int'(cnt_q[3])][3'd7 - cnt_q[2:0]];
		end
	end

	always_comb begin
		for (int c = 0; c < 16; c++) begin
			xbits[c] = (pal_q[c][11] | pal_q[c][7] | pal_q[c][3]) & (seen_q[c] | (c == 0));
		end
	end
	assign ext  = |xbits;
	assign hi   = pal_q[cnt_q][15:8];
	assign lo   = pal_q[cnt_q][7:0];
	assign used = (cnt_q == 4'd0) || seen_q[cnt_q];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pifd_pkg::BK_RUN: begin
				if (is_group && can_emit && cnt_q == 4'd15 && head_cmd.last) begin
					state_d = pifd_pkg::BK_PAL;
				end
			end
			pifd_pkg::BK_PAL: begin
				if (can_emit && cnt_q == 4'd15) begin
					state_d = pifd_pkg::BK_RUN;
				end
			end
			default: state_d = pifd_pkg::BK_RUN;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		emit     = 1'b0;
		emit_pix = 1'b0;
		pal_we   = 1'b0;
		res      = '0;
		unique case (state_q)
			pifd_pkg::BK_RUN: begin
				res.item_kind    = pifd_pkg::KIND_PIXEL;
				res.color_index  = color;
				res.pixel_x      = head_cmd.x_base + {5'b00000, cnt_q};
				res.pixel_y      = head_cmd.row;
				res.header_error = head_cmd.hdr;
				if (head_valid) begin
					if (is_group) begin
						emit     = can_emit;
						emit_pix = can_emit;
						pop      = can_emit && cnt_q == 4'd15;
					end else begin
						pal_we = 1'b1;
						pop    = 1'b1;
					end
				end
			end
			pifd_pkg::BK_PAL: begin
				res.item_kind        = pifd_pkg::KIND_PALETTE;
				res.color_index      = cnt_q;
				res.extended_palette = ext;
				res.header_error     = hdr_q;
				res.final_item       = cnt_q == 4'd15;
				if (used) begin
					if (ext) begin
						res.red_level   = {hi[2:0], hi[3]};
						res.green_level = {lo[6:4], lo[7]};
						res.blue_level  = {lo[2:0], lo[3]};
					end else begin
						res.red_level   = {1'b0, hi[2:0]};
						res.green_level = {1'b0, lo[6:4]};
						res.blue_level  = {1'b0, lo[2:0]};
					end
				end
				emit = can_emit;
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pifd_pkg::BK_RUN;
			cnt_q       <= '0;
			seen_q      <= '0;
			hdr_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				cnt_q       <= cnt_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (emit_pix) begin
				hdr_q  <= head_cmd.hdr;
				seen_q <= ((head_cmd.fresh && cnt_q == 4'd0) ? 16'd0 : seen_q)
					| (16'd1 << color);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
		if (pal_we) begin
			if (head_cmd.kind == pifd_pkg::CMD_PAL_HI) begin
				pal_q[head_cmd.pal_idx][15:8] <= head_cmd.grp[0];
			end else begin
				pal_q[head_cmd.pal_idx][7:0] <= head_cmd.grp[0];
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/planar_image_file_decoder.sv
`default_nettype none
// Decodes a four-bitplane image file arriving one byte per beat. The front end takes a byte
// every cycle while its four-entry command queue has room; the back end gives one result per
// cycle while a command waits and the result port is not stalled, so a group of eight pixel
// bytes yields sixteen pixel results and the result port sets the sustained rate. Header and
// palette bytes give no result beats. After the last image byte the back end gives sixteen
// palette entries before it takes the next queued command. No clearing pass follows reset.
module planar_image_file_decoder (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    byte_valid,
	output logic                   byte_stall,
	input  pifd_pkg::byte_beat_t   byte_data,
	output logic                   result_valid,
	input  wire                    result_stall,
	output pifd_pkg::result_beat_t result_data
);

	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_head_valid;
	pifd_pkg::cmd_t q_cmd;
	pifd_pkg::cmd_t q_head;

	pifd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	pifd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head_cmd   (q_head)
	);

	pifd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_head_valid),
		.head_cmd     (q_head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule
`default_nettype wire

FILE: rtl/pifd_checker.sv
`default_nettype none
module pifd_checker (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    result_valid,
	input wire                    result_stall,
	input pifd_pkg::result_beat_t result_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_data))
		else $error("stalled result beat changed");

	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.final_item |->
			result_data.item_kind == pifd_pkg::KIND_PALETTE
			&& result_data.color_index == 4'd15)
		else $error("final beat is not palette entry 15");

	a_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.item_kind == pifd_pkg::KIND_PIXEL |->
			result_data.red_level == 4'd0 && result_data.green_level == 4'd0
			&& result_data.blue_level == 4'd0 && !result_data.extended_palette)
		else $error("pixel beat carries palette levels");

	a_palette: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.item_kind == pifd_pkg::KIND_PALETTE |->
			result_data.pixel_x == 9'd0 && result_data.pixel_y == 8'd0)
		else $error("palette beat carries coordinates");

endmodule

bind planar_image_file_decoder pifd_checker u_pifd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_data  (result_data)
);
`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	class image_decoder_shadow;
		int unsigned position;
		int unsigned column;
		int unsigned row;
		logic [7:0] group [8];
		logic [15:0] palette [16];
		logic [15:0] seen;
		logic hdr_bad;
		pifd_pkg::result_beat_t owed_results [$];
		int errors;

		function new();
			position = 0;
			column = 0;
			row = 0;
			seen = '0;
			hdr_bad = 1'b0;
			errors = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("%0t ns: %s", $time, msg);
		endtask

		function void push_pixels();
			pifd_pkg::result_beat_t r;
			logic [3:0] color;
			for (int i = 0; i < 16; i++) begin
				for (int b = 0; b < 4; b++)
					color[b] = group[2 * b + i / 8][7 - i % 8];
				seen[color] = 1'b1;
				r = '0;
				r.item_kind = pifd_pkg::KIND_PIXEL;
				r.color_index = color;
				r.pixel_x = 9'(column * 16 + i);
				r.pixel_y = 8'(row);
				r.header_error = hdr_bad;
				owed_results.push_back(r);
			end
		endfunction

		function void push_palette();
			pifd_pkg::result_beat_t r;
			logic [7:0] hi;
			logic [7:0] lo;
			logic wide;
			wide = 1'b0;
			for (int c = 0; c < 16; c++) begin
				hi = palette[c][15:8];
				lo = palette[c][7:0];
				if ((c == 0 || seen[c]) && (hi[3] || lo[7] || lo[3]))
					wide = 1'b1;
			end
			for (int c = 0; c < 16; c++) begin
				hi = palette[c][15:8];
				lo = palette[c][7:0];
				r = '0;
				r.item_kind = pifd_pkg::KIND_PALETTE;
				r.color_index = 4'(c);
				r.extended_palette = wide;
				r.header_error = hdr_bad;
				r.final_item = (c == 15);
				if (c == 0 || seen[c]) begin
					if (wide) begin
						r.red_level = {hi[2:0], hi[3]};
						r.green_level = {lo[6:4], lo[7]};
						r.blue_level = {lo[2:0], lo[3]};
					end else begin
						r.red_level = {1'b0, hi[2:0]};
						r.green_level = {1'b0, lo[6:4]};
						r.blue_level = {1'b0, lo[2:0]};
					end
				end
				owed_results.push_back(r);
			end
		endfunction

		function void note_byte(pifd_pkg::byte_beat_t b);
			int unsigned off;
			if (b.new_file) begin
				position = 0;
				seen = '0;
				hdr_bad = 1'b0;
				column = 0;
				row = 0;
			end
			if (position >= pifd_pkg::IMAGE_END)
				return;
			if (position < pifd_pkg::HEAD_BYTES) begin
				if (b.file_byte != 8'h00)
					hdr_bad = 1'b1;
			end else if (position < pifd_pkg::DATA_START) begin
				off = position - pifd_pkg::HEAD_BYTES;
				if (off % 2 == 0)
					palette[off / 2][15:8] = b.file_byte;
				else
					palette[off / 2][7:0] = b.file_byte;
			end else begin
				off = (position - pifd_pkg::DATA_START) % 8;
				group[off] = b.file_byte;
				if (off == 7) begin
					push_pixels();
					column++;
					if (column >= pifd_pkg::GROUPS_PER_ROW) begin
						column = 0;
						row++;
					end
				end
			end
			position++;
			if (position == pifd_pkg::IMAGE_END)
				push_palette();
		endfunction

		task check_field(string name, logic [8:0] got, logic [8:0] want);
			if (got !== want)
				report($sformatf("%s: got %0h, want %0h", name, got, want));
		endtask

		task check_result(pifd_pkg::result_beat_t got);
			pifd_pkg::result_beat_t want;
			if (owed_results.size() == 0) begin
				report($sformatf("result beat %h with nothing owed", got));
				return;
			end
			want = owed_results.pop_front();
			check_field("item_kind", got.item_kind, want.item_kind);
			check_field("color_index", got.color_index, want.color_index);
			check_field("pixel_x", got.pixel_x, want.pixel_x);
			check_field("pixel_y", got.pixel_y, want.pixel_y);
			check_field("red_level", got.red_level, want.red_level);
			check_field("green_level", got.green_level, want.green_level);
			check_field("blue_level", got.blue_level, want.blue_level);
			check_field("extended_palette", got.extended_palette, want.extended_palette);
			check_field("header_error", got.header_error, want.header_error);
			check_field("final_item", got.final_item, want.final_item);
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   byte_valid = 1'b0;
	logic                   byte_stall;
	pifd_pkg::byte_beat_t   byte_data = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	pifd_pkg::result_beat_t result_data;

	image_decoder_shadow shadow = new();

	int byte_beats = 0;
	int result_beats = 0;
	bit byte_calm = 1'b0;
	bit result_calm = 1'b0;
	int hold_left = 3;

	planar_image_file_decoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_data   (byte_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			shadow.check_result(result_data);
			if (result_beats % 64 == 0)
				result_calm = ($urandom_range(0, 3) != 0);
			result_beats++;
			hold_left = result_calm ? 0 : $urandom_range(0, 7);
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic send_byte(logic [7:0] value, logic mark);
		pifd_pkg::byte_beat_t b;
		int gap;
		b.file_byte = value;
		b.new_file = mark;
		if (byte_beats % 64 == 0)
			byte_calm = ($urandom_range(0, 3) != 0);
		byte_beats++;
		gap = byte_calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= b;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		shadow.note_byte(b);
		@(negedge clk);
	endtask

	task automatic send_directed();
		logic [7:0] groups [3][8];
		logic [15:0] word;
		groups = '{'{8{8'h00}}, '{8{8'hFF}},
			'{8'hAA, 8'h55, 8'hCC, 8'h33, 8'hF0, 8'h0F, 8'hFF, 8'h00}};
		// no mark after reset; nonzero second header byte
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		for (int c = 0; c < 16; c++) begin
			word = (c == 0) ? 16'h0000 : (c == 1) ? 16'hFFFF : 16'($urandom);
			send_byte(word[15:8], 1'b0);
			send_byte(word[7:0], 1'b0);
		end
		for (int g = 0; g < 3; g++)
			for (int i = 0; i < 8; i++)
				send_byte(groups[g][i], 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7E, 1'b0);
		send_byte(8'h12, 1'b1);
		send_byte(8'h00, 1'b0);
	endtask

	task automatic send_random_files(int count);
		int sent;
		int len;
		logic mark;
		logic [7:0] value;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 33) : $urandom_range(42, 100);
			for (int i = 0; i < len; i++) begin
				mark = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
				value = (i < 2 && $urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom);
				send_byte(value, mark);
			end
			sent += len;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_directed();
		send_random_files(60);
		byte_valid <= 1'b0;
		while (shadow.owed_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (shadow.errors == 0 && shadow.owed_results.size() == 0)
			$display("planar_image_file_decoder test passed");
		else
			$display("planar_image_file_decoder test failed");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("planar_image_file_decoder test failed");
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
rtl/pifd_pkg.sv
rtl/pifd_front.sv
rtl/pifd_fifo.sv
rtl/pifd_back.sv
rtl/planar_image_file_decoder.sv
rtl/pifd_checker.sv
sim/tb_top.sv
